@@ rtl/smde_pkg.sv @@
package smde_pkg;

   // Fixed field widths of the column read and of the event.
   localparam int COLUMN_W    = 4;
   localparam int ROW_BITS_W  = 8;
   localparam int BIT_IDX_W   = 3;
   localparam int EVENT_W     = 8;

   // Defaults of the top-level parameters.
   localparam int COLUMNS_DEFAULT   = 16;
   localparam int ROW_WIDTH_DEFAULT = 8;

   // Request codes carried in the func field.
   localparam logic FUNC_SCAN  = 1'b0;
   localparam logic FUNC_PRIME = 1'b1;

   // One column read as held in the input register.
   typedef struct packed {
      logic                  func;
      logic [COLUMN_W-1:0]   column;
      logic [ROW_BITS_W-1:0] row_bits;
   } read_item_type;

   // Work handed from the input stage to the event sequencer.
   typedef struct packed {
      logic [COLUMN_W-1:0]   column;
      logic [ROW_BITS_W-1:0] row_bits;
      logic [ROW_BITS_W-1:0] changed;
   } emit_load_type;

endpackage

@@ rtl/smde_req_if.sv @@
interface smde_req_if;

   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [smde_pkg::COLUMN_W-1:0]       column;
   logic [smde_pkg::ROW_BITS_W-1:0]     row_bits;

   modport source (output valid, output func, output column, output row_bits, input ready);
   modport sink   (input valid, input func, input column, input row_bits, output ready);

endinterface

@@ rtl/smde_rsp_if.sv @@
interface smde_rsp_if;

   logic                                valid;
   logic                                ready;
   logic [smde_pkg::EVENT_W-1:0]        event_number;
   logic                                pressed;
   logic                                last;

   modport source (output valid, output event_number, output pressed, output last, input ready);
   modport sink   (input valid, input event_number, input pressed, input last, output ready);

endinterface

@@ rtl/smde_store.sv @@
module smde_store #(
   parameter int COLUMNS   = smde_pkg::COLUMNS_DEFAULT,
   parameter int ROW_WIDTH = smde_pkg::ROW_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  smde_pkg::read_item_type           item,
   output logic [smde_pkg::ROW_BITS_W-1:0]   changed
);

   localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

   logic [ROW_WIDTH-1:0] debounced_ff [COLUMNS];
   logic [ROW_WIDTH-1:0] previous_ff  [COLUMNS];

   logic                 in_range;
   logic [IDX_W-1:0]     idx;
   logic [ROW_WIDTH-1:0] row;
   logic [ROW_WIDTH-1:0] deb_rd;
   logic [ROW_WIDTH-1:0] prev_rd;
   logic [ROW_WIDTH-1:0] changed_w;

   // Decode the column and read both stores of it.
   always_comb begin
      in_range = ({1'b0, item.column} < (smde_pkg::COLUMN_W + 1)'(COLUMNS));
      idx      = item.column[IDX_W-1:0];
      row      = item.row_bits[ROW_WIDTH-1:0];
      deb_rd   = in_range ? debounced_ff[idx] : '0;
      prev_rd  = in_range ? previous_ff[idx] : '0;
   end

   // A bit changes when it held over two reads and differs from the debounced value.
   always_comb begin
      if (in_range && item.func == smde_pkg::FUNC_SCAN) begin
         changed_w = ~(row ^ prev_rd) & (row ^ deb_rd);
      end else begin
         changed_w = '0;
      end
      changed = smde_pkg::ROW_BITS_W'(changed_w);
   end

   // Priming loads both stores; a scan records the raw value and applies every toggle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < COLUMNS; c++) begin
            debounced_ff[c] <= '0;
            previous_ff[c]  <= '0;
         end
      end else if (update && in_range) begin
         previous_ff[idx] <= row;
         if (item.func == smde_pkg::FUNC_PRIME) begin
            debounced_ff[idx] <= row;
         end else begin
            debounced_ff[idx] <= deb_rd ^ changed_w;
         end
      end
   end

endmodule

@@ rtl/smde_emit.sv @@
module smde_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  smde_pkg::emit_load_type load_data,
   output logic                    free,
   smde_rsp_if.source              rsp_port
);

   logic                                valid_ff;
   logic [smde_pkg::COLUMN_W-1:0]       column_ff;
   logic [smde_pkg::ROW_BITS_W-1:0]     row_ff;
   logic [smde_pkg::ROW_BITS_W-1:0]     mask_ff;

   logic [smde_pkg::BIT_IDX_W-1:0]      bit_idx;
   logic [smde_pkg::ROW_BITS_W-1:0]     remaining;
   logic                                pressed;
   logic                                last;
   logic                                take;

   // Pick the lowest pending bit and clear it from the remaining set.
   always_comb begin
      bit_idx = '0;
      for (int b = smde_pkg::ROW_BITS_W - 1; b >= 0; b--) begin
         if (mask_ff[b]) begin
            bit_idx = smde_pkg::BIT_IDX_W'(b);
         end
      end
      remaining = mask_ff & ~(smde_pkg::ROW_BITS_W'(1) << bit_idx);
      pressed   = ~row_ff[bit_idx];
      last      = (remaining == '0);
      take      = valid_ff && rsp_port.ready;
      free      = !valid_ff || (take && last);
   end

   assign rsp_port.valid        = valid_ff;
   assign rsp_port.event_number = {column_ff, bit_idx, pressed};
   assign rsp_port.pressed      = pressed;
   assign rsp_port.last         = last;

   // Hold one column's pending changes and step through them one item per cycle while the response port is ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take && last) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         column_ff <= load_data.column;
         row_ff    <= load_data.row_bits;
         mask_ff   <= load_data.changed;
      end else if (take) begin
         mask_ff   <= remaining;
      end
   end

endmodule

@@ rtl/switch_matrix_debounce_events.sv @@
// Switch matrix debouncer: each request item is one read of one column (func, column,
// active-low row bits). The block keeps a raw and a debounced value per column and sends
// one response item for every bit that held its new value over two reads and differs from
// the debounced value, lowest bit first, with last set on the final one; func=1 primes
// both values of the column and sends nothing, and a column of COLUMNS or more is ignored.
// A read is taken into an input register, its changes are found there in the next cycle,
// and the event sequencer then sends one item per cycle while the response port is ready,
// the first in the cycle after the read leaves the input register. A read with no events
// leaves the input register at once, even while earlier events are still being sent; a
// read with events waits there until the sequencer, which has a single output slot, is
// free. The next read is taken as soon as the input register moves on. Both stored values
// of every column reset to zero.
module switch_matrix_debounce_events #(
   parameter int COLUMNS   = smde_pkg::COLUMNS_DEFAULT,
   parameter int ROW_WIDTH = smde_pkg::ROW_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   smde_req_if.sink    req_port,
   smde_rsp_if.source  rsp_port
);

   localparam logic [smde_pkg::ROW_BITS_W-1:0] ROW_MASK =
      smde_pkg::ROW_BITS_W'((1 << ROW_WIDTH) - 1);

   logic                            a_valid_ff;
   smde_pkg::read_item_type         a_item_ff;

   logic [smde_pkg::ROW_BITS_W-1:0] changed;
   logic                            emit_free;
   logic                            a_go;
   logic                            emit_load;
   smde_pkg::emit_load_type         load_data;

   // The input stage moves on at once when it has no events, else when the sequencer is free.
   always_comb begin
      a_go             = a_valid_ff && ((changed == '0) || emit_free);
      emit_load        = a_go && (changed != '0);
      req_port.ready   = !a_valid_ff || a_go;
      load_data.column   = a_item_ff.column;
      load_data.row_bits = a_item_ff.row_bits;
      load_data.changed  = changed;
   end

   // Input register; row bits above the row width are cleared on entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         a_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.ready && req_port.valid) begin
         a_item_ff.func     <= req_port.func;
         a_item_ff.column   <= req_port.column;
         a_item_ff.row_bits <= req_port.row_bits & ROW_MASK;
      end
   end

   smde_store #(
      .COLUMNS   (COLUMNS),
      .ROW_WIDTH (ROW_WIDTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .update  (a_go),
      .item    (a_item_ff),
      .changed (changed)
   );

   smde_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (emit_load),
      .load_data (load_data),
      .free      (emit_free),
      .rsp_port  (rsp_port)
   );

endmodule
